// ===== hw/rtl/psns_pkg.sv =====
// Shared types and codes of the point store with nearest search.
package psns_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam int NEAR_IDX_W = 10;
  localparam int DIST_W     = 34;
  localparam int SQ_W       = 32;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] radius;
  } psns_item_t;

  typedef struct packed {
    logic                  found;
    logic [NEAR_IDX_W-1:0] near_index;
    logic signed [15:0]    near_x;
    logic signed [15:0]    near_y;
    logic signed [15:0]    near_z;
    logic signed [15:0]    near_radius;
    logic [DIST_W-1:0]     dist_squared;
    logic                  overflow;
  } psns_result_t;

  // One stored particle.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] radius;
  } psns_entry_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } psns_point_t;

  // Write-side commands to the particle store.
  typedef struct packed {
    logic        append;
    logic        clear;
    psns_entry_t entry;
  } psns_wr_t;

endpackage

// ===== hw/rtl/psns_in_if.sv =====
// Input channel carrying append, query and clear items.
interface psns_in_if;
  import psns_pkg::*;

  logic       valid;
  logic       ready;
  psns_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/psns_out_if.sv =====
// Result channel carrying one result per item.
interface psns_out_if;
  import psns_pkg::*;

  logic         valid;
  logic         ready;
  psns_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/point_store_nearest_search.sv =====
// Top level of the point store with brute-force nearest search.
//
// Items arrive on in_ch and each one yields exactly one result on out_ch;
// both are valid/ready channels and a transfer happens when both are high.
// An append stores a particle at the end of the store, or reports overflow
// when the store holds MAX_PARTICLES particles. A clear empties the store.
// Both pass their result through the holding register into the output
// register. A query reads every stored particle once through the single
// memory read port; a query on an empty store skips the scan and
// answers with found low. One item is worked on at a time.
// A finished result waits in the output register while the next item is
// already taken in; when the receiver stalls, that next result waits in
// a holding register and in_ch deasserts ready until the output drains.
// Reset empties the store at once through its fill count; the memory is
// not swept and no entry beyond the count is ever read.
module point_store_nearest_search #(
  parameter int MAX_PARTICLES = 1024
) (
  input logic     clk,
  input logic     rst_n,
  psns_in_if.sink   in_ch,
  psns_out_if.source out_ch
);
  import psns_pkg::*;

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]   state_r, state_nxt;
  psns_result_t res_r, res_nxt;
  logic         out_valid_r;
  psns_result_t out_data_r;
  logic         in_xfer;
  logic         slot_free;

  psns_wr_t     wr;
  logic         scan_start;
  psns_point_t  query;
  logic [CW-1:0] count;
  logic         full;
  logic         rd_en;
  logic [IW-1:0] rd_addr;
  psns_entry_t  rd_data;
  logic         scan_done;
  logic [IW-1:0] best_idx;
  psns_entry_t  best_entry;
  logic [DIST_W-1:0] best_dist;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // Store commands decoded from the accepted item.
  assign wr.append       = in_xfer && (in_ch.data.kind == KIND_APPEND);
  assign wr.clear        = in_xfer && (in_ch.data.kind == KIND_CLEAR);
  assign wr.entry.x      = in_ch.data.pos_x;
  assign wr.entry.y      = in_ch.data.pos_y;
  assign wr.entry.z      = in_ch.data.pos_z;
  assign wr.entry.radius = in_ch.data.radius;

  assign scan_start = in_xfer && (in_ch.data.kind == KIND_QUERY) && (count != '0);
  assign query.x    = in_ch.data.pos_x;
  assign query.y    = in_ch.data.pos_y;
  assign query.z    = in_ch.data.pos_z;

  psns_store #(.MAX_PARTICLES(MAX_PARTICLES)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .count   (count),
    .full    (full)
  );

  psns_scan #(.MAX_PARTICLES(MAX_PARTICLES)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scan_start),
    .count      (count),
    .query      (query),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .done       (scan_done),
    .best_idx   (best_idx),
    .best_entry (best_entry),
    .best_dist  (best_dist)
  );

  // Control sequence and the result held until the output register is free.
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          res_nxt = '0;
          if (in_ch.data.kind == KIND_APPEND) begin
            res_nxt.overflow = full;
          end
          state_nxt = scan_start ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          res_nxt.found        = 1'b1;
          res_nxt.near_index   = NEAR_IDX_W'(best_idx);
          res_nxt.near_x       = best_entry.x;
          res_nxt.near_y       = best_entry.y;
          res_nxt.near_z       = best_entry.z;
          res_nxt.near_radius  = best_entry.radius;
          res_nxt.dist_squared = best_dist;
          res_nxt.overflow     = 1'b0;
          state_nxt            = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Output register: loaded from the holding register when the slot frees up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && slot_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== hw/rtl/psns_store.sv =====
// Particle memory with fill count, append write port and one registered read port.
module psns_store #(
  parameter int MAX_PARTICLES = 1024,
  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1,
  localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psns_pkg::psns_wr_t    wr,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  output psns_pkg::psns_entry_t rd_data,
  output logic [CW-1:0]         count,
  output logic                  full
);
  import psns_pkg::*;

  psns_entry_t mem [MAX_PARTICLES];
  psns_entry_t rd_data_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign full    = (count_r == CW'(MAX_PARTICLES));
  assign count   = count_r;
  assign rd_data = rd_data_r;

  // The fill count marks which entries hold particles.
  always_comb begin
    count_nxt = count_r;
    if (wr.clear) begin
      count_nxt = '0;
    end else if (wr.append && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Append writes at the current end of the store.
  always_ff @(posedge clk) begin
    if (wr.append && !full) begin
      mem[count_r[IW-1:0]] <= wr.entry;
    end
  end

  // Synchronous read: the read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/psns_scan.sv =====
// Scan sequencer and distance pipeline that tracks the nearest particle.
module psns_scan #(
  parameter int MAX_PARTICLES = 1024,
  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1,
  localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [CW-1:0]         count,
  input  psns_pkg::psns_point_t query,
  output logic                  rd_en,
  output logic [IW-1:0]         rd_addr,
  input  psns_pkg::psns_entry_t rd_data,
  output logic                  done,
  output logic [IW-1:0]         best_idx,
  output psns_pkg::psns_entry_t best_entry,
  output logic [psns_pkg::DIST_W-1:0] best_dist
);
  import psns_pkg::*;

  // Absolute difference of two signed coordinates, always fits 16 bits.
  function automatic logic [15:0] mag_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    logic signed [16:0] n;
    d = {a[15], a} - {b[15], b};
    n = -d;
    return d[16] ? n[15:0] : d[15:0];
  endfunction

  logic          active_r;
  logic [IW-1:0] addr_r;
  logic [IW-1:0] last_r;
  psns_point_t   q_r;
  logic [CW-1:0] count_m1;

  logic          s1_valid_r, s1_last_r;
  logic [IW-1:0] s1_idx_r;

  logic          s2_valid_r, s2_last_r;
  logic [IW-1:0] s2_idx_r;
  psns_entry_t   s2_entry_r;
  logic [SQ_W-1:0] s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic [15:0]   mx, my, mz;

  logic          s3_valid_r, s3_last_r;
  logic [IW-1:0] s3_idx_r;
  psns_entry_t   s3_entry_r;
  logic [DIST_W-1:0] s3_sum_r;

  logic          done_r;
  logic [IW-1:0] best_idx_r;
  psns_entry_t   best_entry_r;
  logic [DIST_W-1:0] best_dist_r;

  assign count_m1 = count - CW'(1);
  assign rd_en    = active_r;
  assign rd_addr  = addr_r;

  // Address sequencer: one memory read per cycle from entry zero to the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
    end else if (active_r && (addr_r == last_r)) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= '0;
      last_r <= count_m1[IW-1:0];
      q_r    <= query;
    end else if (active_r) begin
      addr_r <= addr_r + IW'(1);
    end
  end

  // Stage one tags the read data as it leaves the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= (addr_r == last_r);
    s1_idx_r  <= addr_r;
  end

  // Stage two squares the per-axis differences.
  assign mx = mag_diff(rd_data.x, q_r.x);
  assign my = mag_diff(rd_data.y, q_r.y);
  assign mz = mag_diff(rd_data.z, q_r.z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_last_r  <= s1_last_r;
    s2_idx_r   <= s1_idx_r;
    s2_entry_r <= rd_data;
    s2_sqx_r   <= {16'b0, mx} * {16'b0, mx};
    s2_sqy_r   <= {16'b0, my} * {16'b0, my};
    s2_sqz_r   <= {16'b0, mz} * {16'b0, mz};
  end

  // Stage three adds the squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_last_r  <= s2_last_r;
    s3_idx_r   <= s2_idx_r;
    s3_entry_r <= s2_entry_r;
    s3_sum_r   <= DIST_W'(s2_sqx_r) + DIST_W'(s2_sqy_r) + DIST_W'(s2_sqz_r);
  end

  // Stage four keeps the best so far; strict compare keeps the earliest on ties.
  always_ff @(posedge clk) begin
    if (s3_valid_r && ((s3_idx_r == '0) || (s3_sum_r < best_dist_r))) begin
      best_idx_r   <= s3_idx_r;
      best_entry_r <= s3_entry_r;
      best_dist_r  <= s3_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= s3_valid_r && s3_last_r;
    end
  end

  assign done       = done_r;
  assign best_idx   = best_idx_r;
  assign best_entry = best_entry_r;
  assign best_dist  = best_dist_r;

endmodule

// ===== test/tb_point_store_nearest_search.sv =====
// Testbench of the point store with nearest search: directed table, random episodes, predictor.
module tb_point_store_nearest_search;
  import psns_pkg::*;

  localparam int STORE_DEPTH  = 1024;
  localparam int RANDOM_ITEMS = 580;
  localparam int CALM_ITEMS   = 80;
  localparam int SMALL_STORE  = 48;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] DIST_MAX = 34'd12884508675;
  localparam logic signed [15:0] CORNER_VALUES [6] =
    '{16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh7FFE, 16'sh7FFF};

  typedef struct {
    psns_item_t   item;
    bit           typed;
    psns_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  psns_in_if  in_ch ();
  psns_out_if out_ch ();

  // Shadow copy of the particle store and the results still owed by the block.
  psns_entry_t  shadow_store [STORE_DEPTH];
  int           shadow_count = 0;
  psns_result_t pending_results [$];
  int           error_count = 0;
  bit           gap_enable = 1'b0;
  bit           stall_enable = 1'b0;
  int           stall_left = 0;

  point_store_nearest_search #(.MAX_PARTICLES(STORE_DEPTH)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic psns_item_t make_item(logic [1:0] kind, logic signed [15:0] x,
                                           logic signed [15:0] y, logic signed [15:0] z,
                                           logic signed [15:0] r);
    psns_item_t it;
    it.kind   = kind;
    it.pos_x  = x;
    it.pos_y  = y;
    it.pos_z  = z;
    it.radius = r;
    return it;
  endfunction

  function automatic psns_result_t hit_result(int idx, logic signed [15:0] x,
                                              logic signed [15:0] y, logic signed [15:0] z,
                                              logic signed [15:0] r, logic [DIST_W-1:0] d);
    psns_result_t res;
    res = '0;
    res.found        = 1'b1;
    res.near_index   = NEAR_IDX_W'(idx);
    res.near_x       = x;
    res.near_y       = y;
    res.near_z       = z;
    res.near_radius  = r;
    res.dist_squared = d;
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] squared_distance(psns_entry_t e, psns_item_t it);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'($signed(e.x)) - longint'($signed(it.pos_x));
    dy = longint'($signed(e.y)) - longint'($signed(it.pos_y));
    dz = longint'($signed(e.z)) - longint'($signed(it.pos_z));
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Applies one item to the shadow store and returns the result it must produce.
  function automatic psns_result_t apply_item(psns_item_t it);
    psns_result_t res;
    logic [DIST_W-1:0] d;
    res = '0;
    case (it.kind)
      KIND_APPEND: begin
        if (shadow_count >= STORE_DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          shadow_store[shadow_count] = '{x: it.pos_x, y: it.pos_y, z: it.pos_z,
                                         radius: it.radius};
          shadow_count++;
        end
      end
      KIND_QUERY: begin
        // Strict less-than keeps the earliest particle on a tie.
        for (int i = 0; i < shadow_count; i++) begin
          d = squared_distance(shadow_store[i], it);
          if (!res.found || d < res.dist_squared) begin
            res = hit_result(i, shadow_store[i].x, shadow_store[i].y, shadow_store[i].z,
                             shadow_store[i].radius, d);
          end
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Coordinates lean toward a small box and the corners so that ties and extremes are common.
  function automatic logic signed [15:0] rand_coord();
    logic signed [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 16)) - 16'sd8;
      2: v = CORNER_VALUES[$urandom_range(0, 5)];
      default: v = 16'($urandom_range(0, 2047)) - 16'sd1024;
    endcase
    return v;
  endfunction

  function automatic psns_item_t random_append();
    return make_item(KIND_APPEND, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  // When the store is not empty, half the queries land on or next to a stored particle.
  function automatic psns_item_t random_query();
    psns_entry_t e;
    if (shadow_count > 0 && $urandom_range(0, 1) == 1) begin
      e = shadow_store[$urandom_range(0, shadow_count - 1)];
      return make_item(KIND_QUERY, e.x + 16'($urandom_range(0, 4)) - 16'sd2,
                       e.y + 16'($urandom_range(0, 4)) - 16'sd2,
                       e.z + 16'($urandom_range(0, 4)) - 16'sd2, rand_coord());
    end
    return make_item(KIND_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Drives one item, waits for its transfer and records the result it owes.
  task automatic transfer_item(psns_item_t it, bit typed, psns_result_t want);
    psns_result_t predicted;
    if (gap_enable && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 13)) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_item(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Receiver stalls come in bursts whose length is drawn at random.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Each result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    psns_result_t want;
    psns_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", want.found, got.found);
        check_field("near_index", want.near_index, got.near_index);
        check_field("near_x", $signed(want.near_x), $signed(got.near_x));
        check_field("near_y", $signed(want.near_y), $signed(got.near_y));
        check_field("near_z", $signed(want.near_z), $signed(got.near_z));
        check_field("near_radius", $signed(want.near_radius), $signed(got.near_radius));
        check_field("dist_squared", want.dist_squared, got.dist_squared);
        check_field("overflow", want.overflow, got.overflow);
      end
    end
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("tb_point_store_nearest_search: done, errors");
    $finish;
  end

  initial begin
    directed_row_t rows [$];
    psns_result_t none;
    psns_item_t it;
    psns_entry_t e;
    int random_items;
    int len;
    int pick;
    bit fill_done;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    none         = '0;

    // Directed table: empty store, unused kind, corners, maximum distance and ties.
    rows.push_back('{make_item(KIND_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000),
                     1'b1, none});
    rows.push_back('{make_item(KIND_UNUSED, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA),
                     1'b1, none});
    rows.push_back('{make_item(KIND_CLEAR, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF),
                     1'b1, none});
    rows.push_back('{make_item(KIND_QUERY, 16'sh1234, 16'shF00D, 16'sh0001, 16'sh0000),
                     1'b1, none});
    rows.push_back('{make_item(KIND_APPEND, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF),
                     1'b1, none});
    rows.push_back('{make_item(KIND_QUERY, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000),
                     1'b1, hit_result(0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                      DIST_MAX)});
    rows.push_back('{make_item(KIND_APPEND, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000),
                     1'b1, none});
    rows.push_back('{make_item(KIND_QUERY, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh0000),
                     1'b1, hit_result(0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '0)});
    rows.push_back('{make_item(KIND_QUERY, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000),
                     1'b1, hit_result(1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, '0)});
    rows.push_back('{make_item(KIND_QUERY, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000),
                     1'b0, none});
    rows.push_back('{make_item(KIND_CLEAR, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000),
                     1'b1, none});
    rows.push_back('{make_item(KIND_APPEND, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0080),
                     1'b1, none});
    rows.push_back('{make_item(KIND_APPEND, 16'shFF00, 16'sh0000, 16'sh0000, 16'shFF80),
                     1'b1, none});
    rows.push_back('{make_item(KIND_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000),
                     1'b0, none});
    rows.push_back('{make_item(KIND_APPEND, 16'sh0100, 16'sh0000, 16'sh0000, 16'shFFFF),
                     1'b1, none});
    rows.push_back('{make_item(KIND_QUERY, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000),
                     1'b0, none});
    rows.push_back('{make_item(KIND_QUERY, 16'shFED4, 16'sh0005, 16'shFFF9, 16'sh0000),
                     1'b0, none});
    rows.push_back('{make_item(KIND_UNUSED, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF),
                     1'b1, none});
    rows.push_back('{make_item(KIND_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000),
                     1'b0, none});
    rows.push_back('{make_item(KIND_APPEND, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA),
                     1'b1, none});
    rows.push_back('{make_item(KIND_QUERY, 16'sh5550, 16'shAAAF, 16'sh5555, 16'sh0000),
                     1'b0, none});
    rows.push_back('{make_item(KIND_CLEAR, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000),
                     1'b1, none});
    rows.push_back('{make_item(KIND_QUERY, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000),
                     1'b1, none});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    gap_enable   = 1'b1;
    stall_enable = 1'b1;
    foreach (rows[i]) transfer_item(rows[i].item, rows[i].typed, rows[i].want);

    // Random episodes over a small store, with one pass that fills it to the top.
    random_items = 0;
    fill_done    = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      gap_enable   = $urandom_range(0, 3) != 0;
      stall_enable = $urandom_range(0, 3) != 0;
      if (!fill_done && random_items >= RANDOM_ITEMS / 2) begin
        transfer_item(make_item(KIND_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                                rand_coord()), 1'b0, none);
        while (shadow_count < STORE_DEPTH) transfer_item(random_append(), 1'b0, none);
        repeat (3) transfer_item(random_append(), 1'b0, none);
        e = shadow_store[STORE_DEPTH - 1];
        transfer_item(make_item(KIND_QUERY, e.x, e.y, e.z, rand_coord()), 1'b0, none);
        repeat (2) transfer_item(random_query(), 1'b0, none);
        transfer_item(make_item(KIND_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                                rand_coord()), 1'b0, none);
        fill_done = 1'b1;
      end
      len = $urandom_range(4, 30);
      repeat (len) begin
        if (random_items >= RANDOM_ITEMS - CALM_ITEMS) begin
          gap_enable   = 1'b0;
          stall_enable = 1'b0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45 && shadow_count < SMALL_STORE) begin
          it = random_append();
        end else if (pick < 45 || (pick >= 88 && pick < 94)) begin
          it = make_item(KIND_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end else if (pick < 88) begin
          it = random_query();
        end else begin
          it = make_item(KIND_UNUSED, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
        transfer_item(it, 1'b0, none);
        if (it.kind != KIND_UNUSED) random_items++;
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_point_store_nearest_search: done, clean");
    end else begin
      $display("tb_point_store_nearest_search: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/psns_pkg.sv
hw/rtl/psns_in_if.sv
hw/rtl/psns_out_if.sv
hw/rtl/psns_store.sv
hw/rtl/psns_scan.sv
hw/rtl/point_store_nearest_search.sv
test/tb_point_store_nearest_search.sv
